@@ rtl/core/sort8_pkg.sv @@
// ----------------------------------------------------------------------------
// sort8_pkg
// Types and the compare-exchange layer map of the eight-lane sorting network.
// ----------------------------------------------------------------------------
package sort8_pkg;

    localparam int LANES      = 8;
    localparam int LANE_W     = 16;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int NUM_LAYERS = 6;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [LANES-1:0] vec_t;
    typedef logic [LANE_IDX_W-1:0] lane_idx_t;
    typedef lane_idx_t [LANES-1:0] partner_map_t;

    typedef struct packed {
        lane_t value0;
        lane_t value1;
        lane_t value2;
        lane_t value3;
        lane_t value4;
        lane_t value5;
        lane_t value6;
        lane_t value7;
    } in_req_t;

    typedef struct packed {
        lane_t sorted0;
        lane_t sorted1;
        lane_t sorted2;
        lane_t sorted3;
        lane_t sorted4;
        lane_t sorted5;
        lane_t sorted6;
        lane_t sorted7;
    } out_req_t;

    // partner lane of every lane per layer; a lane paired with itself passes through
    localparam lane_idx_t PARTNER [NUM_LAYERS][LANES] = '{
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7},
        '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7},
        '{3'd0, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7}
    };

endpackage

@@ rtl/core/sort8_stage.sv @@
// ----------------------------------------------------------------------------
// sort8_stage
// One registered layer of compare-exchange cells with valid and stall.
// ----------------------------------------------------------------------------
module sort8_stage
    import sort8_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  partner_map_t partner,
    input  logic         in_valid,
    input  vec_t         in_data,
    output logic         in_stall,
    output logic         out_valid,
    output vec_t         out_data,
    input  logic         out_stall
);

    logic valid_reg;
    logic valid_next;
    vec_t data_reg;
    vec_t data_next;
    logic load;

    assign in_stall = valid_reg && out_stall;
    assign load     = !in_stall;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_t mine;
            lane_t other;
            lane_t lo;
            lane_t hi;
            mine  = in_data[l];
            other = in_data[partner[l]];
            lo    = (other < mine) ? other : mine;
            hi    = (other < mine) ? mine : other;
            // lower lane of a pair keeps the minimum
            data_next[l] = (lane_idx_t'(l) < partner[l]) ? lo : hi;
        end
    end

    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/sort_eight_u16.sv @@
// ----------------------------------------------------------------------------
// sort_eight_u16
// Ascending sort of eight unsigned 16-bit values.
// ----------------------------------------------------------------------------
// A 19-comparator sorting network cut into six register stages, one layer of
// compare-exchange cells each. A request enters every cycle unless in_stall is
// high; each stage registers it in turn. A stall at the output holds the
// full stages and stops the input only once the pipeline has no empty stage.
module sort_eight_u16
    import sort8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_req_t  in_data,
    output logic     in_stall,
    output logic     out_valid,
    output out_req_t out_data,
    input  logic     out_stall
);

    logic [NUM_LAYERS:0] valid_chain;
    logic [NUM_LAYERS:0] stall_chain;
    vec_t                data_chain [NUM_LAYERS+1];

    assign valid_chain[0] = in_valid;
    assign in_stall       = stall_chain[0];
    assign data_chain[0]  = '{in_data.value7, in_data.value6, in_data.value5, in_data.value4,
                              in_data.value3, in_data.value2, in_data.value1, in_data.value0};

    for (genvar s = 0; s < NUM_LAYERS; s++)
    begin : g_layer
        partner_map_t map;

        for (genvar l = 0; l < LANES; l++)
        begin : g_map
            assign map[l] = PARTNER[s][l];
        end

        sort8_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .partner   (map),
            .in_valid  (valid_chain[s]),
            .in_data   (data_chain[s]),
            .in_stall  (stall_chain[s]),
            .out_valid (valid_chain[s+1]),
            .out_data  (data_chain[s+1]),
            .out_stall (stall_chain[s+1])
        );
    end

    assign stall_chain[NUM_LAYERS] = out_stall;
    assign out_valid               = valid_chain[NUM_LAYERS];

    assign out_data.sorted0 = data_chain[NUM_LAYERS][0];
    assign out_data.sorted1 = data_chain[NUM_LAYERS][1];
    assign out_data.sorted2 = data_chain[NUM_LAYERS][2];
    assign out_data.sorted3 = data_chain[NUM_LAYERS][3];
    assign out_data.sorted4 = data_chain[NUM_LAYERS][4];
    assign out_data.sorted5 = data_chain[NUM_LAYERS][5];
    assign out_data.sorted6 = data_chain[NUM_LAYERS][6];
    assign out_data.sorted7 = data_chain[NUM_LAYERS][7];

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-lane unsigned 16-bit sorter.
// ----------------------------------------------------------------------------
// Requests go in as bursts with random gaps. A directed set covers the corner
// cases first: all zeros, all ones, duplicates, pre-sorted and reversed input,
// and values that would order differently if compared as signed. A random set
// follows. Each accepted request is sorted in the bench, and every result is
// compared lane by lane with the oldest pending expectation. The output is
// stalled in changing patterns.
// ----------------------------------------------------------------------------
module tb
    import sort8_pkg::*;
();

    localparam int NUM_RANDOM  = 500;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_TICKS = 20;

    typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
    typedef enum int unsigned {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_RISING, FILL_FALLING}
        fill_mode_t;

    class sorted_board_t;
        out_req_t    pending[$];
        int unsigned errors;
        int unsigned requests;
        int unsigned results;

        // ascending insertion sort of the eight lanes
        function out_req_t sort_ascending(in_req_t req);
            vec_t  src;
            vec_t  dst;
            lane_t v[LANES];
            lane_t t;
            int    j;
            src = vec_t'(req);
            for (int i = 0; i < LANES; i++)
                v[i] = src[LANES-1-i];
            for (int i = 1; i < LANES; i++)
            begin
                t = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > t)
                begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = t;
            end
            for (int i = 0; i < LANES; i++)
                dst[LANES-1-i] = v[i];
            return out_req_t'(dst);
        endfunction

        function void note_request(in_req_t req);
            pending.push_back(sort_ascending(req));
            requests++;
        endfunction

        function void check_sorted(out_req_t got);
            out_req_t want;
            vec_t     wv;
            vec_t     gv;
            results++;
            if (pending.size() == 0)
            begin
                errors++;
                $error("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            wv   = vec_t'(want);
            gv   = vec_t'(got);
            for (int i = 0; i < LANES; i++)
            begin
                if (gv[LANES-1-i] !== wv[LANES-1-i])
                begin
                    errors++;
                    $error("sorted%0d: expected %h, got %h", i, wv[LANES-1-i], gv[LANES-1-i]);
                end
            end
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    in_req_t  in_data   = '0;
    logic     in_stall;
    logic     out_valid;
    out_req_t out_data;
    logic     out_stall = 1'b0;

    sorted_board_t board = new();

    int unsigned burst_left;
    int unsigned directed_count;
    int unsigned stalled_cycles;
    int unsigned idle_cycles;
    int unsigned stall_left;
    stall_mode_t stall_mode;

    sort_eight_u16 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input in_req_t req);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(req);
    endtask

    task automatic send_lanes(input lane_t a0, input lane_t a1, input lane_t a2,
                              input lane_t a3, input lane_t a4, input lane_t a5,
                              input lane_t a6, input lane_t a7);
        in_req_t req;
        req.value0 = a0;
        req.value1 = a1;
        req.value2 = a2;
        req.value3 = a3;
        req.value4 = a4;
        req.value5 = a5;
        req.value6 = a6;
        req.value7 = a7;
        directed_count++;
        send_request(req);
    endtask

    function automatic in_req_t random_request();
        fill_mode_t mode;
        vec_t       pv;
        lane_t      base;
        lane_t      picks[4];
        mode     = fill_mode_t'($urandom_range(0, 4));
        base     = lane_t'($urandom_range(0, 16'hFFF0));
        picks[0] = 16'h0000;
        picks[1] = 16'hFFFF;
        picks[2] = 16'h8000;
        picks[3] = 16'h7FFF;
        for (int i = 0; i < LANES; i++)
        begin
            case (mode)
                FILL_FULL:    pv[LANES-1-i] = lane_t'($urandom);
                FILL_NARROW:  pv[LANES-1-i] = lane_t'($urandom_range(0, 3));
                FILL_EXTREME: pv[LANES-1-i] = picks[$urandom_range(0, 3)];
                FILL_RISING:  pv[LANES-1-i] = base + lane_t'(i * $urandom_range(0, 2));
                default:      pv[LANES-1-i] = base + lane_t'((LANES - i) * $urandom_range(0, 2));
            endcase
        end
        return in_req_t'(pv);
    endfunction

    // output side: check results and stall on a pattern of its own
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_sorted(out_data);
        if (rst_n && out_valid && out_stall)
            stalled_cycles++;
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(4, 60);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_left % 16) < 5);
        endcase
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results pending", board.pending.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_lanes(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_lanes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_lanes(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                   16'h0004, 16'h0005, 16'h0006, 16'h0007);
        send_lanes(16'h0007, 16'h0006, 16'h0005, 16'h0004,
                   16'h0003, 16'h0002, 16'h0001, 16'h0000);
        send_lanes(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                   16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_lanes(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                   16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_lanes(16'h0001, 16'h0004, 16'h0010, 16'h0040,
                   16'h0100, 16'h0400, 16'h1000, 16'h4000);
        send_lanes(16'h8000, 16'h2000, 16'h0800, 16'h0200,
                   16'h0080, 16'h0020, 16'h0008, 16'h0002);
        send_lanes(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                   16'h5555, 16'h5555, 16'h5555, 16'h5555);
        send_lanes(16'h0003, 16'h0003, 16'h0001, 16'h0001,
                   16'h0002, 16'h0002, 16'h0000, 16'h0000);
        send_lanes(16'hFFFF, 16'h0012, 16'h0340, 16'h0005,
                   16'h7000, 16'h0123, 16'h00AB, 16'h0C00);
        send_lanes(16'h0012, 16'h0340, 16'h0005, 16'h7000,
                   16'h0123, 16'h00AB, 16'h0C00, 16'hFFFF);
        send_lanes(16'hF000, 16'hEEEE, 16'hFFFE, 16'hA5A5,
                   16'hC3C3, 16'h9999, 16'hFF00, 16'h0000);
        // mixed signs: must order as unsigned
        send_lanes(16'h8000, 16'h7FFF, 16'hFFFE, 16'h0001,
                   16'h8001, 16'h7FFE, 16'h0000, 16'hFFFF);
        send_lanes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_lanes(16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_lanes(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                   16'h1234, 16'h1234, 16'hFEDC, 16'hFEDC);

        for (int n = 0; n < NUM_RANDOM; n++)
            send_request(random_request());

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        $display("sorted %0d requests (%0d directed, rest random) and checked %0d results",
                 board.requests, directed_count, board.results);
        $display("output held by stall on %0d cycles, %0d lane mismatches",
                 stalled_cycles, board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
